[src/chm_pkg.sv]
package chm_pkg;

  // counts and lengths up to sixteen needle characters
  localparam int LEN_W        = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int SEQ_LEN      = 7;
  localparam int SEQ_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd2;

  // ESC [ 1 ; 3 7 m and ESC [ 0 ; 3 7 m, element 0 first on the wire
  localparam logic [SEQ_LEN-1:0][7:0] SEQ_ON =
    {8'h6D, 8'h37, 8'h33, 8'h3B, 8'h31, 8'h5B, 8'h1B};
  localparam logic [SEQ_LEN-1:0][7:0] SEQ_OFF =
    {8'h6D, 8'h37, 8'h33, 8'h3B, 8'h30, 8'h5B, 8'h1B};

  typedef struct packed {
    logic             hit;
    logic             last;
    logic [LEN_W-1:0] hit_len;
    logic [LEN_W-1:0] emit_cnt;
  } cmd_ctl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[src/chm_queue.sv]
module chm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty,
  output logic             full
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign rdata     = mem_r[rd_ptr_r];
  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue pushed while full");

endmodule

[src/chm_front.sv]
module chm_front #(
  parameter int MAX_NEEDLE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [chm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [chm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_text_byte,
  input  logic                                in_string_end,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [MAX_NEEDLE-1:0][7:0]          cmd_win,
  output chm_pkg::cmd_ctl_t                   cmd_ctl
);

  localparam int LW    = chm_pkg::LEN_W;
  localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

  logic [chm_pkg::CFG_DATA_W-1:0] needle_low_r;
  logic [chm_pkg::CFG_DATA_W-1:0] needle_high_r;
  logic [LW-1:0]                  needle_len_r;
  logic [MAX_NEEDLE-1:0][7:0]     win_r, win_nxt;
  logic [LW-1:0]                  cnt_r, cnt_nxt;

  logic [2*chm_pkg::CFG_DATA_W-1:0] needle;
  logic [MAX_NEEDLE-1:0][7:0]       win_new;
  logic [LW-1:0]                    len;
  logic [LW-1:0]                    cnt_new;
  logic [LW-1:0]                    drop;
  logic [LW-1:0]                    emit_cnt;
  logic [LW:0]                      src;
  logic                             match;
  logic                             reach;
  logic                             hit;
  logic                             accept;

  assign needle   = {needle_high_r, needle_low_r};
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    len = (needle_len_r > LW'(MAX_NEEDLE)) ? LW'(MAX_NEEDLE) : needle_len_r;
    cnt_new = cnt_r + LW'(1);
    match = 1'b1;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      win_new[i] = (LW'(i) == cnt_r) ? in_text_byte : win_r[i];
      if ((LW'(i) < len) && (chm_pkg::fold_case(win_new[i]) !=
          chm_pkg::fold_case(needle[i*8 +: 8]))) begin
        match = 1'b0;
      end
    end
    // a zero length never matches and passes each byte straight through
    reach    = (cnt_new >= len);
    hit      = (len != '0) && reach && match;
    drop     = hit ? len : (reach ? LW'(1) : '0);
    emit_cnt = in_string_end ? cnt_new : drop;
    cnt_nxt  = in_string_end ? '0 : (cnt_new - drop);
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      src = (LW+1)'(i) + {1'b0, drop};
      win_nxt[i] = (src < (LW+1)'(MAX_NEEDLE)) ? win_new[src[IDX_W-1:0]] : win_new[i];
    end
  end

  assign q_push           = accept && (hit || (emit_cnt != '0));
  assign cmd_win          = win_new;
  assign cmd_ctl.hit      = hit;
  assign cmd_ctl.last     = in_string_end;
  assign cmd_ctl.hit_len  = len;
  assign cmd_ctl.emit_cnt = emit_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_low_r  <= '0;
      needle_high_r <= '0;
      needle_len_r  <= LW'(1);
      cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          chm_pkg::REG_NEEDLE_LOW:    needle_low_r  <= cfg_data;
          chm_pkg::REG_NEEDLE_HIGH:   needle_high_r <= cfg_data;
          chm_pkg::REG_NEEDLE_LENGTH: needle_len_r  <= cfg_data[LW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) accept && in_string_end |=> cnt_r == '0)
    else $error("window not flushed at end of string");
  assert property (@(posedge clk) disable iff (!rst_n) accept && in_string_end |-> q_push)
    else $error("end of string produced no transaction");

endmodule

[src/chm_back.sv]
module chm_back #(
  parameter int MAX_NEEDLE = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  logic [MAX_NEEDLE-1:0][7:0] q_win,
  input  chm_pkg::cmd_ctl_t          q_ctl,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_run_last,
  output logic                       out_string_done
);

  localparam int LW    = chm_pkg::LEN_W;
  localparam int SW    = chm_pkg::SEQ_W;
  localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam logic [SW-1:0] SEQ_LAST = SW'(chm_pkg::SEQ_LEN - 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_ON,
    PH_BODY,
    PH_OFF,
    PH_TAIL
  } phase_t;

  phase_t           phase_r, phase_nxt, ph;
  logic [SW-1:0]    seq_r, seq_nxt;
  logic [IDX_W-1:0] win_r, win_nxt;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_run_last_r;
  logic             out_string_done_r;

  logic [7:0]       byte_sel;
  logic             final_byte;
  logic [LW-1:0]    win_next_cnt;
  logic             adv;
  logic             fire;

  assign adv   = !out_valid_r || !out_stall;
  assign fire  = adv && q_not_empty;
  assign q_pop = fire && final_byte;

  always_comb begin
    ph = phase_r;
    if (phase_r == PH_START) begin
      ph = q_ctl.hit ? PH_ON : PH_TAIL;
    end
    phase_nxt    = ph;
    seq_nxt      = seq_r;
    win_nxt      = win_r;
    win_next_cnt = LW'(win_r) + LW'(1);
    byte_sel     = '0;
    final_byte   = 1'b0;
    case (ph)
      PH_ON: begin
        byte_sel = chm_pkg::SEQ_ON[seq_r];
        seq_nxt  = seq_r + SW'(1);
        if (seq_r == SEQ_LAST) begin
          seq_nxt   = '0;
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        byte_sel = q_win[win_r];
        win_nxt  = win_r + IDX_W'(1);
        if (win_next_cnt == q_ctl.hit_len) begin
          phase_nxt = PH_OFF;
        end
      end
      PH_OFF: begin
        byte_sel = chm_pkg::SEQ_OFF[seq_r];
        seq_nxt  = seq_r + SW'(1);
        if (seq_r == SEQ_LAST) begin
          seq_nxt = '0;
          if (q_ctl.hit_len == q_ctl.emit_cnt) begin
            final_byte = 1'b1;
          end else begin
            phase_nxt = PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        byte_sel = q_win[win_r];
        win_nxt  = win_r + IDX_W'(1);
        if (win_next_cnt == q_ctl.emit_cnt) begin
          final_byte = 1'b1;
        end
      end
      default: begin
        final_byte = 1'b1;
      end
    endcase
    if (final_byte) begin
      phase_nxt = PH_START;
      seq_nxt   = '0;
      win_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      seq_r       <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r           <= phase_nxt;
        seq_r             <= seq_nxt;
        win_r             <= win_nxt;
        out_valid_r       <= 1'b1;
        out_byte_r        <= byte_sel;
        out_run_last_r    <= final_byte;
        out_string_done_r <= final_byte && q_ctl.last;
      end else if (adv) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_run_last_r;
  assign out_string_done = out_string_done_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_string_done_r |-> out_run_last_r)
    else $error("string end flagged on a byte that does not close its run");

endmodule

[src/case_insensitive_match_highlighter_top.sv]
// Streams a text string one byte per transaction and returns it with every
// leftmost, non-overlapping case-insensitive occurrence of the needle wrapped
// in ESC[1;37m ... ESC[0;37m. The front end holds the pending window and its
// comparator and accepts one input byte per cycle while the queue is not full;
// the back end emits one output byte per cycle from a two-entry command queue
// while out_stall is low. Ordinary bytes flow at one byte per cycle, held in
// the queue and the back end output register. Hits get both escape sequences
// and string ends flush the window; then the queue fills and the input stalls.
module case_insensitive_match_highlighter_top #(
  parameter int MAX_NEEDLE = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [chm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_string_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_run_last,
  output logic                           out_string_done
);

  localparam int QW = MAX_NEEDLE * 8 + $bits(chm_pkg::cmd_ctl_t);

  logic                       q_full;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_not_empty;
  logic [MAX_NEEDLE-1:0][7:0] f_win;
  chm_pkg::cmd_ctl_t          f_ctl;
  logic [MAX_NEEDLE-1:0][7:0] b_win;
  chm_pkg::cmd_ctl_t          b_ctl;
  logic [QW-1:0]              q_wdata;
  logic [QW-1:0]              q_rdata;

  chm_front #(.MAX_NEEDLE(MAX_NEEDLE)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_string_end (in_string_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .cmd_win       (f_win),
    .cmd_ctl       (f_ctl)
  );

  assign q_wdata = {f_win, f_ctl};

  chm_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  assign {b_win, b_ctl} = q_rdata;

  chm_back #(.MAX_NEEDLE(MAX_NEEDLE)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_win           (b_win),
    .q_ctl           (b_ctl),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

endmodule
